// ===== rtl/can_signal_extractor_macros.svh =====
// ---------------------------------------------------------------------------
// can_signal_extractor_macros
// Assertion helpers for the CAN signal extractor. Each expects clk and rst in
// scope.
// ---------------------------------------------------------------------------
`ifndef CAN_SIGNAL_EXTRACTOR_MACROS_SVH
`define CAN_SIGNAL_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define CSX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csx assertion failed");

// next-cycle implication
`define CSX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csx assertion failed");

`endif

// ===== rtl/csx_pkg.sv =====
// ---------------------------------------------------------------------------
// csx_pkg
// Shared types and constants of the CAN signal extractor.
// ---------------------------------------------------------------------------
package csx_pkg;

  localparam int CSX_MAX_ENTRIES = 32;
  localparam int WALK_CAP        = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int ACTIVE_W        = 6;
  localparam int ID_W            = 29;
  localparam int ADDR_W          = 3;

  localparam logic [1:0] KIND_SENSOR = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;

  localparam logic CMD_WRITE = 1'b1;

  // register select is paddr[2]
  localparam logic REG_ACTIVE_SENSORS = 1'b0;
  localparam logic REG_LED_FRAME_ID   = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] frame_id;
    logic [3:0]      length;
    logic [63:0]     payload;
    logic [4:0]      entry_index;
    logic [7:0]      match_mask;
    logic [15:0]     byte_map;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  sensor_index;
    logic [31:0] value;
    logic        log_enable;
    logic        last;
  } rsp_word_t;

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_LED,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] frame_id;
    logic [3:0]      length;
    logic [63:0]     payload;
    logic [4:0]      entry_index;
    logic [7:0]      match_mask;
    logic [15:0]     byte_map;
  } queue_item_t;

  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic [3:0]      length;
    logic [63:0]     cond_bytes;
    logic [7:0]      cond_mask;
    logic [15:0]     byte_map;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PRIME,
    BK_WALK,
    BK_FINAL
  } back_state_t;

endpackage

// ===== rtl/csx_front.sv =====
// ---------------------------------------------------------------------------
// csx_front
// Input register: takes request words and tags each as table write,
// log-enable control frame or lookup frame.
// ---------------------------------------------------------------------------
module csx_front import csx_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  req_word_t       req,
  input  logic [ID_W-1:0] led_frame_id,
  input  logic            q_full,
  output logic            push,
  output queue_item_t     item
);

  logic        fr_valid;
  queue_item_t fr_item;
  queue_item_t fr_item_next;
  logic        accept;

  assign req_stall = fr_valid && q_full;
  assign push      = fr_valid && !q_full;
  assign accept    = req_valid && !req_stall;
  assign item      = fr_item;

  always_comb begin
    fr_item_next.frame_id    = req.frame_id;
    fr_item_next.length      = req.length;
    fr_item_next.payload     = req.payload;
    fr_item_next.entry_index = req.entry_index;
    fr_item_next.match_mask  = req.match_mask;
    fr_item_next.byte_map    = req.byte_map;
    if (req.cmd == CMD_WRITE) begin
      fr_item_next.op = OP_WRITE;
    end else if (req.frame_id == led_frame_id && req.length == 4'd1) begin
      fr_item_next.op = OP_LED;
    end else begin
      fr_item_next.op = OP_FRAME;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (accept) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item <= fr_item_next;
    end
  end

endmodule

// ===== rtl/csx_fifo.sv =====
// ---------------------------------------------------------------------------
// csx_fifo
// Short queue of classified words between front and back.
// ---------------------------------------------------------------------------
module csx_fifo import csx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t wdata,
  input  logic        pop,
  output queue_item_t rdata,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  queue_item_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/csx_back.sv =====
// ---------------------------------------------------------------------------
// csx_back
// Signal table and walker: writes entries, updates the log flag, and walks
// the active entries one per cycle unless stalled; emits a word per match.
// ---------------------------------------------------------------------------
module csx_back import csx_pkg::*; #(
  parameter int MAX_ENTRIES = CSX_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  queue_item_t         head,
  output logic                pop,
  input  logic [ACTIVE_W-1:0] active_sensors,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rsp_word_t           rsp
);

  localparam int DEPTH = (MAX_ENTRIES > WALK_CAP) ? WALK_CAP : MAX_ENTRIES;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_W = IDX_W + 1;

  entry_t           mem [DEPTH];
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             mem_we;

  back_state_t      state;
  back_state_t      state_next;
  queue_item_t      cur;
  logic [IDX_W-1:0] chk_idx;
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] limit_next;
  logic             log_flag;
  logic             in_range;
  logic             out_free;
  logic             advance;
  logic             walk_end;
  logic             hit;
  logic             cond_ok;
  logic [31:0]      hit_value;
  logic             rsp_load;
  rsp_word_t        rsp_next;

  assign out_free = !rsp_valid || !rsp_stall;
  assign in_range = ({1'b0, head.entry_index} < 6'(MAX_ENTRIES));
  assign walk_end = (({1'b0, chk_idx} + LIM_W'(1)) == limit);
  assign limit_next = (active_sensors > ACTIVE_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                          : LIM_W'(active_sensors);
  assign wr_addr = head.entry_index[IDX_W-1:0];

  always_comb begin
    wr_entry.frame_id   = head.frame_id;
    wr_entry.length     = head.length;
    wr_entry.cond_bytes = head.payload;
    wr_entry.cond_mask  = head.match_mask;
    wr_entry.byte_map   = head.byte_map;
  end

  // entry match and value assembly
  always_comb begin
    logic [3:0] nib;
    cond_ok = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < cur.length && rd_entry.cond_mask[b] &&
          rd_entry.cond_bytes[8*b +: 8] != cur.payload[8*b +: 8]) begin
        cond_ok = 1'b0;
      end
    end
    hit = (rd_entry.frame_id == cur.frame_id) && !rd_entry.byte_map[3] &&
          (rd_entry.length == cur.length) && cond_ok;
    hit_value = '0;
    for (int b = 0; b < 4; b++) begin
      nib = rd_entry.byte_map[4*b +: 4];
      if (!nib[3]) begin
        hit_value[8*b +: 8] = cur.payload[{nib[2:0], 3'b000} +: 8];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (head.op == OP_FRAME && limit_next != '0) begin
            state_next = BK_PRIME;
          end else begin
            state_next = BK_FINAL;
          end
        end
      end
      BK_PRIME: state_next = BK_WALK;
      BK_WALK: begin
        if (advance && walk_end) begin
          state_next = BK_FINAL;
        end
      end
      BK_FINAL: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    rd_addr  = '0;
    advance  = 1'b0;
    rsp_load = 1'b0;
    rsp_next = '0;
    rsp_next.log_enable = log_flag;
    unique case (state)
      BK_IDLE: begin
        pop    = !q_empty;
        mem_we = !q_empty && head.op == OP_WRITE && in_range;
      end
      BK_PRIME: rd_addr = '0;
      BK_WALK: begin
        advance  = !hit || out_free;
        rd_addr  = advance ? chk_idx + IDX_W'(1) : chk_idx;
        rsp_load = hit && out_free;
        rsp_next.kind         = KIND_SENSOR;
        rsp_next.sensor_index = 5'(chk_idx);
        rsp_next.value        = hit_value;
      end
      BK_FINAL: begin
        rsp_load = out_free;
        rsp_next.last = 1'b1;
        if (cur.op == OP_WRITE) begin
          rsp_next.kind         = KIND_ACK;
          rsp_next.sensor_index = cur.entry_index;
        end else begin
          rsp_next.kind = KIND_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      log_flag  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && head.op == OP_LED) begin
        log_flag <= |head.payload[7:0];
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head;
      limit <= limit_next;
    end
    if (state == BK_PRIME) begin
      chk_idx <= '0;
    end else if (advance) begin
      chk_idx <= chk_idx + IDX_W'(1);
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

// ===== rtl/can_signal_extractor.sv =====
// ---------------------------------------------------------------------------
// can_signal_extractor
// Decodes sensor values from received CAN frames against a signal table.
// ---------------------------------------------------------------------------
// A request word is either a received frame or a table entry write. A write
// returns one acknowledge word. A frame carrying the log-enable control id
// with length one returns one done word. Any other frame walks the active
// table entries at one entry per cycle, unless the output is stalled on a
// match, through the table memory's single read port, covering
// min(active_sensors, MAX_ENTRIES, 32) entries, and returns one word per
// matching entry in index order and then a done word with last set. An input
// register and a two-word queue let new requests arrive while a frame is
// being walked.
`include "can_signal_extractor_macros.svh"

module can_signal_extractor import csx_pkg::*; #(
  parameter int MAX_ENTRIES = CSX_MAX_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_word_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_word_t         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [ACTIVE_W-1:0] active_sensors;
  logic [ID_W-1:0]     led_frame_id;
  logic                cfg_we;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  queue_item_t         q_wdata;
  queue_item_t         q_rdata;
  logic                rsp_sensor;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign rsp_sensor = rsp_valid && rsp.kind == KIND_SENSOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sensors <= '0;
      led_frame_id   <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ACTIVE_SENSORS: active_sensors <= pwdata[ACTIVE_W-1:0];
        REG_LED_FRAME_ID:   led_frame_id   <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ACTIVE_SENSORS: prdata = 32'(active_sensors);
      REG_LED_FRAME_ID:   prdata = 32'(led_frame_id);
      default: ;
    endcase
  end

  csx_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .led_frame_id (led_frame_id),
    .q_full       (q_full),
    .push         (q_push),
    .item         (q_wdata)
  );

  csx_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  csx_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .head           (q_rdata),
    .pop            (q_pop),
    .active_sensors (active_sensors),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp)
  );

  `CSX_ASSERT_NOW(a_no_queue_overflow, q_push, !q_full)
  `CSX_ASSERT_NOW(a_only_sensor_not_last, rsp_valid && !rsp.last, rsp.kind == KIND_SENSOR)
  `CSX_ASSERT_NOW(a_sensor_in_active, rsp_sensor, 6'(rsp.sensor_index) < active_sensors)
  `CSX_ASSERT_NEXT(a_pop_needs_word, q_pop, !$past(q_empty))

endmodule
